// ----- src/acsd_pkg.sv -----
package acsd_pkg;

  localparam int unsigned Channels    = 4;
  localparam int unsigned PosW        = 2;
  localparam int unsigned StatusW     = 9;
  localparam int unsigned LimitsW     = 11;
  localparam int unsigned CfgDataW    = 11;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned ValueW      = 16;

  localparam logic [11:0] DataMask    = 12'hFFF;
  localparam logic [12:0] DataOffset  = 13'h7FF;
  localparam int unsigned FracBits    = 3;

  localparam logic [StatusW-1:0] StatusReset = 9'd256;
  localparam logic [LimitsW-1:0] LimitsReset = 11'd1536;

  typedef enum logic [1:0] {
    CfgStatus = 2'd0,
    CfgLimits = 2'd1,
    CfgSelect = 2'd2
  } acsd_cfg_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatVerifyErr = 2'd1,
    StatChanOff   = 2'd2
  } acsd_status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     overload;
    acsd_status_e             status;
  } acsd_result_t;

  typedef struct packed {
    logic            emit;
    logic            sel_on;
    logic [2:0]      count;
    logic [PosW-1:0] pos_next;
    acsd_result_t    result;
  } acsd_dec_t;

endpackage

// ----- src/adc_channel_sample_demux_decoder_top.sv -----
// Demultiplexes the interleaved words of a four-channel converter buffer and
// decodes the words of the selected channel. One request per cycle is taken
// and its result shows next cycle on the output register; the input stalls
// only while that register holds a result not taken in the same cycle. Words
// of other channels give no output; with the selected channel off every word
// gives a channel-off result. tuser is the restart flag of a buffer's first
// word. Write the configuration only while no request is in flight.
module adc_channel_sample_demux_decoder_top import acsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [SampleW-1:0]  s_axis_tdata_i,   // sample_word
  input  logic                s_axis_tuser_i,   // restart

  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ValueW-1:0]   m_axis_tdata_o,   // scaled_value
  output logic [2:0]          m_axis_tuser_o    // overload, result_status
);

  logic [StatusW-1:0] status_q;
  logic [LimitsW-1:0] limits_q;
  logic [1:0]         sel_q;
  logic [PosW-1:0]    pos_q;
  logic               out_valid_q, out_valid_d;
  acsd_result_t       out_q;
  acsd_dec_t          dec;
  logic               s_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= StatusReset;
      limits_q <= LimitsReset;
      sel_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStatus: status_q <= cfg_wdata_i[StatusW-1:0];
        CfgLimits: limits_q <= cfg_wdata_i[LimitsW-1:0];
        CfgSelect: sel_q    <= cfg_wdata_i[1:0];
        default:   ;
      endcase
    end
  end

  acsd_decode u_decode (
    .sample_i  (s_axis_tdata_i),
    .restart_i (s_axis_tuser_i),
    .pos_i     (pos_q),
    .status_i  (status_q),
    .limits_i  (limits_q),
    .sel_i     (sel_q),
    .dec_o     (dec)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (s_acc && dec.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_acc) begin
        pos_q <= dec.pos_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && dec.emit) begin
      out_q <= dec.result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.value;
  assign m_axis_tuser_o  = {out_q.status, out_q.overload};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !dec.sel_on |=> out_valid_q && (out_q.status == StatChanOff))
    else $error("disabled channel request did not give a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (dec.count == 3'd0) |=> pos_q == '0)
    else $error("position moved with no channel enabled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overload |-> (out_q.status == StatOk) && (out_q.value == '0))
    else $error("overload result carries data or error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != StatOk) |-> !out_q.overload && (out_q.value == '0))
    else $error("error result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result is stalled");

endmodule

// ----- src/acsd_decode.sv -----
module acsd_decode import acsd_pkg::*; (
  input  logic [SampleW-1:0] sample_i,
  input  logic               restart_i,
  input  logic [PosW-1:0]    pos_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [LimitsW-1:0] limits_i,
  input  logic [1:0]         sel_i,
  output acsd_dec_t          dec_o
);

  always_comb begin
    logic [PosW-1:0]        pos_eff;
    logic [2:0]             count;
    logic [1:0]             slot;
    logic                   sel_on;
    logic [1:0]             gain;
    logic signed [12:0]     centered;
    logic signed [ValueW-1:0] scaled;
    logic [2:0]             pos_inc;

    pos_eff = restart_i ? '0 : pos_i;
    count   = '0;
    slot    = '0;
    sel_on  = 1'b0;
    for (int unsigned c = 0; c < Channels; c++) begin
      if (status_i[4+c]) begin
        if (sel_i == 2'(c)) begin
          sel_on = 1'b1;
          slot   = count[1:0];
        end
        count = count + 3'd1;
      end
    end

    gain     = limits_i[2*sel_i +: 2];
    centered = $signed({1'b0, sample_i[11:0] & DataMask}) - $signed(DataOffset);
    scaled   = ValueW'(centered) <<< FracBits;

    dec_o        = '0;
    dec_o.sel_on = sel_on;
    dec_o.count  = count;
    dec_o.result.status = StatOk;

    if (!sel_on) begin
      dec_o.emit          = 1'b1;
      dec_o.result.status = StatChanOff;
    end else if (pos_eff == slot) begin
      dec_o.emit = 1'b1;
      if (sample_i[13]) begin
        dec_o.result.status = StatVerifyErr;
      end else if (sample_i[12]) begin
        dec_o.result.overload = 1'b1;
      end else if (status_i[8] && (sample_i[15:14] != sel_i)) begin
        dec_o.result.status = StatVerifyErr;
      end else begin
        dec_o.result.value = scaled >>> gain;
      end
    end

    pos_inc = {1'b0, pos_eff} + 3'd1;
    if ((count == 3'd0) || (pos_inc >= count)) begin
      dec_o.pos_next = '0;
    end else begin
      dec_o.pos_next = pos_inc[PosW-1:0];
    end
  end

endmodule
